@@ hw/rtl/filled_circle_span_generator_defines.svh @@
// Assertion macros shared by the span generator checker.
// No dependencies; included by file name.
`ifndef FILLED_CIRCLE_SPAN_GENERATOR_DEFINES_SVH
`define FILLED_CIRCLE_SPAN_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define FCSG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fcsg check failed");

// Next-cycle implication, disabled while in reset.
`define FCSG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fcsg check failed");

`endif

@@ hw/rtl/fcsg_pkg.sv @@
// Shared types and constants for the filled circle span generator.
// No dependencies.
package fcsg_pkg;

    localparam int OUT_W    = 12;
    localparam int CENTER_W = 10;
    localparam int RADIUS_W = 5;
    localparam int STEP_W   = 6;
    localparam int DEC_W    = 10;
    localparam int PH_W     = 2;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 5'd10;

    localparam logic [DEC_W-1:0] DEC_INIT      = 10'd3;
    localparam logic [DEC_W-1:0] DEC_STEP_BIAS = 10'd10;
    localparam logic [DEC_W-1:0] DEC_KEEP_BIAS = 10'd6;

    // Span order within one walk point
    localparam logic [PH_W-1:0] PH_ROW_PX = 2'd0;  // row cy+x
    localparam logic [PH_W-1:0] PH_ROW_PY = 2'd1;  // row cy+y
    localparam logic [PH_W-1:0] PH_ROW_MY = 2'd2;  // row cy-y
    localparam logic [PH_W-1:0] PH_ROW_MX = 2'd3;  // row cy-x

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef struct packed {
        logic [OUT_W-1:0]         cx;
        logic [OUT_W-1:0]         cy;
        logic signed [STEP_W-1:0] x;
        logic signed [STEP_W-1:0] y;
        logic                     last;
    } point_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef enum logic [1:0] {
        WK_IDLE = 2'b01,
        WK_RUN  = 2'b10
    } walk_state_t;

endpackage

@@ hw/rtl/fcsg_queue.sv @@
// Two-entry point queue between the walk engine and the span emitter.
// Depends on fcsg_pkg.
module fcsg_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  fcsg_pkg::point_t  push_data,
    input  logic              pop,
    output fcsg_pkg::point_t  pop_data,
    output fcsg_pkg::q_stat_t stat
);

    fcsg_pkg::point_t mem [fcsg_pkg::QUEUE_DEPTH];

    logic [fcsg_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [fcsg_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [fcsg_pkg::QCNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + fcsg_pkg::QCNT_W'(push) - fcsg_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data   = mem[rd_ptr_reg];
    assign stat.full  = (count_reg == fcsg_pkg::QCNT_W'(fcsg_pkg::QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

@@ hw/rtl/fcsg_walk.sv @@
// Front end: takes a center, runs the integer circle walk, one point per cycle
// while the queue is not full. Depends on fcsg_pkg; feeds fcsg_queue.
module fcsg_walk
#(
    parameter int MAX_RADIUS = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [fcsg_pkg::CENTER_W-1:0]   center_x,
    input  logic [fcsg_pkg::CENTER_W-1:0]   center_y,
    input  logic [fcsg_pkg::RADIUS_W-1:0]   radius,
    output logic                            push,
    output fcsg_pkg::point_t                point,
    input  fcsg_pkg::q_stat_t               qstat
);

    localparam logic [fcsg_pkg::RADIUS_W-1:0] RMAX = fcsg_pkg::RADIUS_W'(MAX_RADIUS);
    localparam int EXT_W = fcsg_pkg::DEC_W - fcsg_pkg::STEP_W;

    fcsg_pkg::walk_state_t state_reg, state_next;

    logic [fcsg_pkg::OUT_W-1:0]         cx_reg, cx_next;
    logic [fcsg_pkg::OUT_W-1:0]         cy_reg, cy_next;
    logic signed [fcsg_pkg::STEP_W-1:0] x_reg, x_next;
    logic signed [fcsg_pkg::STEP_W-1:0] y_reg, y_next;
    logic [fcsg_pkg::DEC_W-1:0]         d_reg, d_next;

    logic                               accept;
    logic                               done;
    logic                               d_pos;
    logic [fcsg_pkg::RADIUS_W-1:0]      r_sat;
    logic signed [fcsg_pkg::STEP_W-1:0] x_inc;
    logic signed [fcsg_pkg::STEP_W-1:0] y_dec;
    logic [fcsg_pkg::DEC_W-1:0]         x_ext;
    logic [fcsg_pkg::DEC_W-1:0]         y_ext;

    assign in_stall = (state_reg != fcsg_pkg::WK_IDLE);
    assign accept   = in_valid && (state_reg == fcsg_pkg::WK_IDLE);
    assign r_sat    = (radius > RMAX) ? RMAX : radius;

    // Walk ends after the point at which y has dropped below x
    assign done  = (y_reg < x_reg);
    assign d_pos = !d_reg[fcsg_pkg::DEC_W-1] && (d_reg != '0);
    assign x_inc = x_reg + fcsg_pkg::STEP_W'(1);
    assign y_dec = y_reg - fcsg_pkg::STEP_W'(1);
    assign x_ext = {{EXT_W{x_inc[fcsg_pkg::STEP_W-1]}}, x_inc};
    assign y_ext = {{EXT_W{y_dec[fcsg_pkg::STEP_W-1]}}, y_dec};

    assign push       = (state_reg == fcsg_pkg::WK_RUN) && !qstat.full;
    assign point.cx   = cx_reg;
    assign point.cy   = cy_reg;
    assign point.x    = x_reg;
    assign point.y    = y_reg;
    assign point.last = done;

    always_comb
    begin
        state_next = state_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        d_next     = d_reg;
        unique case (state_reg)
            fcsg_pkg::WK_IDLE:
            begin
                if (accept)
                begin
                    cx_next    = fcsg_pkg::OUT_W'(center_x);
                    cy_next    = fcsg_pkg::OUT_W'(center_y);
                    x_next     = '0;
                    y_next     = fcsg_pkg::STEP_W'(r_sat);
                    d_next     = fcsg_pkg::DEC_INIT - fcsg_pkg::DEC_W'({r_sat, 1'b0});
                    state_next = fcsg_pkg::WK_RUN;
                end
            end
            fcsg_pkg::WK_RUN:
            begin
                if (push)
                begin
                    if (done)
                    begin
                        state_next = fcsg_pkg::WK_IDLE;
                    end
                    else
                    begin
                        x_next = x_inc;
                        if (d_pos)
                        begin
                            y_next = y_dec;
                            d_next = d_reg + ((x_ext - y_ext) << 2) + fcsg_pkg::DEC_STEP_BIAS;
                        end
                        else
                        begin
                            d_next = d_reg + (x_ext << 2) + fcsg_pkg::DEC_KEEP_BIAS;
                        end
                    end
                end
            end
            default:
            begin
                state_next = fcsg_pkg::WK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fcsg_pkg::WK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg <= cx_next;
        cy_reg <= cy_next;
        x_reg  <= x_next;
        y_reg  <= y_next;
        d_reg  <= d_next;
    end

endmodule

@@ hw/rtl/fcsg_span.sv @@
// Back end: expands each queued walk point into four spans, one per cycle
// while the output is not stalled. Depends on fcsg_pkg; reads fcsg_queue.
module fcsg_span
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  fcsg_pkg::point_t                  head,
    input  fcsg_pkg::q_stat_t                 qstat,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [fcsg_pkg::OUT_W-1:0] x_start,
    output logic signed [fcsg_pkg::OUT_W-1:0] x_end,
    output logic signed [fcsg_pkg::OUT_W-1:0] row_y,
    output logic                              last
);

    localparam int EXT_W = fcsg_pkg::OUT_W - fcsg_pkg::STEP_W;

    logic [fcsg_pkg::PH_W-1:0]  phase_reg, phase_next;
    logic                       valid_reg, valid_next;
    logic [fcsg_pkg::OUT_W-1:0] xs_reg, xs_next;
    logic [fcsg_pkg::OUT_W-1:0] xe_reg, xe_next;
    logic [fcsg_pkg::OUT_W-1:0] row_reg, row_next;
    logic                       last_reg, last_next;

    logic                       load;
    logic [fcsg_pkg::OUT_W-1:0] a_ext;
    logic [fcsg_pkg::OUT_W-1:0] b_ext;

    assign a_ext = {{EXT_W{head.x[fcsg_pkg::STEP_W-1]}}, head.x};
    assign b_ext = {{EXT_W{head.y[fcsg_pkg::STEP_W-1]}}, head.y};

    assign load = !qstat.empty && (!valid_reg || !out_stall);
    assign pop  = load && (phase_reg == fcsg_pkg::PH_ROW_MX);

    always_comb
    begin
        phase_next = load ? phase_reg + 1'b1 : phase_reg;
        valid_next = load || (valid_reg && out_stall);
        xs_next    = xs_reg;
        xe_next    = xe_reg;
        row_next   = row_reg;
        last_next  = last_reg;
        if (load)
        begin
            last_next = head.last && (phase_reg == fcsg_pkg::PH_ROW_MX);
            unique case (phase_reg)
                fcsg_pkg::PH_ROW_PX:
                begin
                    xs_next  = head.cx + b_ext;
                    xe_next  = head.cx - b_ext;
                    row_next = head.cy + a_ext;
                end
                fcsg_pkg::PH_ROW_PY:
                begin
                    xs_next  = head.cx + a_ext;
                    xe_next  = head.cx - a_ext;
                    row_next = head.cy + b_ext;
                end
                fcsg_pkg::PH_ROW_MY:
                begin
                    xs_next  = head.cx + a_ext;
                    xe_next  = head.cx - a_ext;
                    row_next = head.cy - b_ext;
                end
                fcsg_pkg::PH_ROW_MX:
                begin
                    xs_next  = head.cx + b_ext;
                    xe_next  = head.cx - b_ext;
                    row_next = head.cy - a_ext;
                end
                default:
                begin
                    xs_next  = xs_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= fcsg_pkg::PH_ROW_PX;
            valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xs_reg   <= xs_next;
        xe_reg   <= xe_next;
        row_reg  <= row_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign x_start   = $signed(xs_reg);
    assign x_end     = $signed(xe_reg);
    assign row_y     = $signed(row_reg);
    assign last      = last_reg;

endmodule

@@ hw/rtl/filled_circle_span_generator.sv @@
// Filled circle span generator: walk engine -> 2-entry point queue -> span emitter.
// The first span passes the walk registers, the queue and the emitter's output registers.
// Throughput: one span per cycle while out_stall is low and a point is queued, four spans
// per walk point; the emitter sets the output rate. The walk makes one point per cycle
// while the queue is not full and takes the next center once its walk ends.
// Reset: asynchronous, clears control state; radius resets to 10.
module filled_circle_span_generator
#(
    parameter int MAX_RADIUS = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [fcsg_pkg::RADIUS_W-1:0]     cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [fcsg_pkg::CENTER_W-1:0]     center_x,
    input  logic [fcsg_pkg::CENTER_W-1:0]     center_y,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [fcsg_pkg::OUT_W-1:0] x_start,
    output logic signed [fcsg_pkg::OUT_W-1:0] x_end,
    output logic signed [fcsg_pkg::OUT_W-1:0] row_y,
    output logic                              last
);

    logic [fcsg_pkg::RADIUS_W-1:0] radius_reg;

    logic              push;
    logic              pop;
    fcsg_pkg::point_t  push_point;
    fcsg_pkg::point_t  head_point;
    fcsg_pkg::q_stat_t qstat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= fcsg_pkg::RADIUS_RESET;
        end
        else if (cfg_we)
        begin
            radius_reg <= cfg_wdata;
        end
    end

    fcsg_walk
    #(
        .MAX_RADIUS (MAX_RADIUS)
    )
    u_walk
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .center_x (center_x),
        .center_y (center_y),
        .radius   (radius_reg),
        .push     (push),
        .point    (push_point),
        .qstat    (qstat)
    );

    fcsg_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_point),
        .pop       (pop),
        .pop_data  (head_point),
        .stat      (qstat)
    );

    fcsg_span u_span
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head_point),
        .qstat     (qstat),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .x_start   (x_start),
        .x_end     (x_end),
        .row_y     (row_y),
        .last      (last)
    );

endmodule

@@ hw/rtl/fcsg_checker.sv @@
// Port-level checks for filled_circle_span_generator, bound to the top level.
// Depends on filled_circle_span_generator_defines.svh.
`include "filled_circle_span_generator_defines.svh"

module fcsg_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [11:0] x_start,
    input logic [11:0] x_end,
    input logic [11:0] row_y,
    input logic        last
);

    logic [11:0] span_sum;

    // Both ends of every span of one circle are mirrored about the center
    assign span_sum = 12'(x_start + x_end);

    `FCSG_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(x_start) && $stable(x_end) && $stable(row_y) && $stable(last))

    // A center transfer starts a walk, so the next center must wait
    `FCSG_ASSERT_NXT(a_busy_after_in, clk, rst_n, in_valid && !in_stall, in_stall)

    `FCSG_ASSERT_IMP(a_same_center, clk, rst_n, out_valid && $past(out_valid && !out_stall && !last), span_sum == $past(span_sum))

endmodule

bind filled_circle_span_generator fcsg_checker u_fcsg_checker (.*);
